// ===== sv/fdns_pkg.sv =====
package fdns_pkg;

  localparam int unsigned NAME_LEN = 11;
  localparam int unsigned HALF_SHIFT = 16;

  localparam logic [7:0] END_MARK       = 8'h00;
  localparam logic [7:0] DELETED_MARK   = 8'hE5;
  localparam logic [7:0] LONG_NAME_ATTR = 8'h0F;

  localparam logic [4:0] FIRST_OFFSET   = 5'd0;
  localparam logic [4:0] ATTR_OFFSET    = 5'd11;
  localparam logic [4:0] CLUS_HI_LO_OFS = 5'd20;
  localparam logic [4:0] CLUS_HI_HI_OFS = 5'd21;
  localparam logic [4:0] CLUS_LO_LO_OFS = 5'd26;
  localparam logic [4:0] CLUS_LO_HI_OFS = 5'd27;
  localparam logic [4:0] SIZE_OFFSET    = 5'd28;
  localparam logic [4:0] LAST_OFFSET    = 5'd31;

  typedef enum logic [1:0] {
    STATUS_FOUND     = 2'd0,
    STATUS_END       = 2'd1,
    STATUS_EXHAUSTED = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    CFG_NAME_HEAD = 1'b0,
    CFG_NAME_TAIL = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] first_cluster;
    logic [31:0] file_size;
  } result_t;

endpackage

// ===== sv/fdns_in_if.sv =====
interface fdns_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       begin_search;
  logic       last_of_directory;

  modport source(output valid, output data_byte, output begin_search,
                 output last_of_directory, input ready);
  modport sink(input valid, input data_byte, input begin_search,
               input last_of_directory, output ready);
endinterface

// ===== sv/fdns_out_if.sv =====
interface fdns_out_if;
  logic              valid;
  logic              ready;
  fdns_pkg::status_t search_status;
  logic [31:0]       first_cluster;
  logic [31:0]       file_size;

  modport source(output valid, output search_status, output first_cluster,
                 output file_size, input ready);
  modport sink(input valid, input search_status, input first_cluster,
               input file_size, output ready);
endinterface

// ===== sv/fdns_cfg_if.sv =====
interface fdns_cfg_if;
  logic               valid;
  logic               ready;
  fdns_pkg::cfg_idx_t index;
  logic [63:0]        data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ===== sv/fdns_entry_scan.sv =====
module fdns_entry_scan (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              begin_search,
  input  logic              last_of_directory,
  input  logic [63:0]       target_name_head,
  input  logic [23:0]       target_name_tail,
  output logic              res_valid,
  output fdns_pkg::result_t res
);

  logic [4:0]  entry_offset, entry_offset_next;
  logic        name_matches, name_matches_next;
  logic        entry_skipped, entry_skipped_next;
  logic [15:0] cluster_high_half, cluster_high_half_next;
  logic [15:0] cluster_low_half, cluster_low_half_next;
  logic [31:0] size_gathered, size_gathered_next;
  logic        search_finished, search_finished_next;

  logic [87:0] target_name;
  logic [4:0]  cur_offset;
  logic [7:0]  target_byte;

  assign target_name = {target_name_tail, target_name_head};

  always_comb begin
    entry_offset_next      = entry_offset;
    name_matches_next      = name_matches;
    entry_skipped_next     = entry_skipped;
    cluster_high_half_next = cluster_high_half;
    cluster_low_half_next  = cluster_low_half;
    size_gathered_next     = size_gathered;
    search_finished_next   = search_finished;
    res_valid              = 1'b0;
    res.status             = fdns_pkg::STATUS_FOUND;
    res.first_cluster      = '0;
    res.file_size          = '0;

    if (accept && begin_search) begin
      entry_offset_next      = '0;
      name_matches_next      = 1'b1;
      entry_skipped_next     = 1'b0;
      cluster_high_half_next = '0;
      cluster_low_half_next  = '0;
      size_gathered_next     = '0;
      search_finished_next   = 1'b0;
    end

    cur_offset  = entry_offset_next;
    target_byte = (cur_offset < 5'(fdns_pkg::NAME_LEN)) ?
                  target_name[{cur_offset[3:0], 3'b000} +: 8] : data_byte;

    if (accept && !search_finished_next) begin
      if (cur_offset == fdns_pkg::FIRST_OFFSET && data_byte == fdns_pkg::END_MARK) begin
        res_valid            = 1'b1;
        res.status           = fdns_pkg::STATUS_END;
        search_finished_next = 1'b1;
      end else begin
        if (cur_offset == fdns_pkg::FIRST_OFFSET && data_byte == fdns_pkg::DELETED_MARK)
          entry_skipped_next = 1'b1;
        if (data_byte != target_byte)
          name_matches_next = 1'b0;
        if (cur_offset == fdns_pkg::ATTR_OFFSET && data_byte == fdns_pkg::LONG_NAME_ATTR)
          entry_skipped_next = 1'b1;
        if (cur_offset == fdns_pkg::CLUS_HI_LO_OFS)
          cluster_high_half_next[7:0] = data_byte;
        if (cur_offset == fdns_pkg::CLUS_HI_HI_OFS)
          cluster_high_half_next[15:8] = data_byte;
        if (cur_offset == fdns_pkg::CLUS_LO_LO_OFS)
          cluster_low_half_next[7:0] = data_byte;
        if (cur_offset == fdns_pkg::CLUS_LO_HI_OFS)
          cluster_low_half_next[15:8] = data_byte;
        if (cur_offset >= fdns_pkg::SIZE_OFFSET)
          size_gathered_next = size_gathered_next |
                               ({24'b0, data_byte} << {cur_offset[1:0], 3'b000});

        entry_offset_next = cur_offset + 5'd1;

        if (cur_offset == fdns_pkg::LAST_OFFSET) begin
          if (name_matches_next && !entry_skipped_next) begin
            res_valid            = 1'b1;
            res.status           = fdns_pkg::STATUS_FOUND;
            res.first_cluster    = {cluster_high_half_next, cluster_low_half_next};
            res.file_size        = size_gathered_next;
            search_finished_next = 1'b1;
          end else begin
            name_matches_next      = 1'b1;
            entry_skipped_next     = 1'b0;
            cluster_high_half_next = '0;
            cluster_low_half_next  = '0;
            size_gathered_next     = '0;
          end
        end

        if (!search_finished_next && last_of_directory) begin
          res_valid            = 1'b1;
          res.status           = fdns_pkg::STATUS_EXHAUSTED;
          search_finished_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_offset      <= '0;
      name_matches      <= 1'b1;
      entry_skipped     <= 1'b0;
      cluster_high_half <= '0;
      cluster_low_half  <= '0;
      size_gathered     <= '0;
      search_finished   <= 1'b0;
    end else begin
      entry_offset      <= entry_offset_next;
      name_matches      <= name_matches_next;
      entry_skipped     <= entry_skipped_next;
      cluster_high_half <= cluster_high_half_next;
      cluster_low_half  <= cluster_low_half_next;
      size_gathered     <= size_gathered_next;
      search_finished   <= search_finished_next;
    end
  end

  // no more than one result per search
  assert property (@(posedge clk) disable iff (rst)
    accept && !begin_search && search_finished |-> !res_valid)
    else $error("result after search finished");

  // offset advances on every scanned byte that does not end the search
  assert property (@(posedge clk) disable iff (rst)
    accept && !begin_search && !search_finished && !res_valid
    |=> entry_offset == $past(entry_offset) + 5'd1)
    else $error("entry offset did not advance");

endmodule

// ===== sv/fdns_out_skid.sv =====
module fdns_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  fdns_pkg::result_t push_data,
  output logic              can_accept,
  fdns_out_if.source        result
);

  logic              out_valid;
  fdns_pkg::result_t out_data;
  logic              skid_valid;
  fdns_pkg::result_t skid_data;
  logic              pop;

  assign pop        = out_valid && result.ready;
  assign can_accept = !skid_valid;

  assign result.valid         = out_valid;
  assign result.search_status = out_data.status;
  assign result.first_cluster = out_data.first_cluster;
  assign result.file_size     = out_data.file_size;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) out_data <= skid_data;
    end else if (push) begin
      if (!out_valid || pop) out_data <= push_data;
      else skid_data <= push_data;
    end
  end

  assert property (@(posedge clk) disable iff (rst) skid_valid |-> out_valid)
    else $error("skid holds a beat while output is empty");

  assert property (@(posedge clk) disable iff (rst) push |-> !skid_valid)
    else $error("result pushed while skid is full");

  assert property (@(posedge clk) disable iff (rst)
    skid_valid && !result.ready |=> skid_valid && out_valid)
    else $error("stalled beat dropped");

endmodule

// ===== sv/fat32_directory_name_search.sv =====
// FAT32 directory name search.
//
// dir_in carries one directory byte per beat in disk order, with
// begin_search marking the first byte of a new search (it clears all scan
// state) and last_of_directory marking the final byte of the directory.
// result carries at most one beat per search: status found, end-of-directory
// entry seen, or data exhausted, plus first cluster and file size (zero
// unless found). cfg writes the padded 8.3 target name: index 0 holds name
// bytes 0..7, index 1 holds the three extension bytes; write it only while
// the block is idle. cfg is always ready.
//
// Throughput: one byte per cycle while the skid stage is not full; the
// per-byte compare and field capture fit between the scan state and the
// result register, which every result beat passes through. When the
// receiver stalls, a result waits in the output register and one more is
// held in a skid stage; dir_in drops ready only while that skid stage is
// full. Reset (rst, synchronous) clears scan state so scanning starts at
// once, clears the target name to zero and empties both stages.
module fat32_directory_name_search (
  input  logic       clk,
  input  logic       rst,
  fdns_in_if.sink    dir_in,
  fdns_out_if.source result,
  fdns_cfg_if.sink   cfg
);

  logic [63:0]       target_name_head;
  logic [23:0]       target_name_tail;
  logic              accept;
  logic              res_valid;
  fdns_pkg::result_t res;
  logic              can_accept;

  assign cfg.ready    = 1'b1;
  assign dir_in.ready = can_accept;
  assign accept       = dir_in.valid && can_accept;

  // hold the target name until the next write
  always_ff @(posedge clk) begin
    if (rst) begin
      target_name_head <= '0;
      target_name_tail <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        fdns_pkg::CFG_NAME_HEAD: target_name_head <= cfg.data;
        fdns_pkg::CFG_NAME_TAIL: target_name_tail <= cfg.data[23:0];
        default: ;
      endcase
    end
  end

  // track entry offset, name compare and field capture per byte
  fdns_entry_scan u_scan (
    .clk               (clk),
    .rst               (rst),
    .accept            (accept),
    .data_byte         (dir_in.data_byte),
    .begin_search      (dir_in.begin_search),
    .last_of_directory (dir_in.last_of_directory),
    .target_name_head  (target_name_head),
    .target_name_tail  (target_name_tail),
    .res_valid         (res_valid),
    .res               (res)
  );

  // register the result beat, with one skid slot for a stalled receiver
  fdns_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .push       (res_valid),
    .push_data  (res),
    .can_accept (can_accept),
    .result     (result)
  );

endmodule
